@@ sv/servo_status_packet_parser_assert.svh @@
// assertion macros for the servo status packet parser checker
// expects clk and rst_n in the scope of each use
`ifndef SERVO_STATUS_PACKET_PARSER_ASSERT_SVH
`define SERVO_STATUS_PACKET_PARSER_ASSERT_SVH

// property holds on every clock edge outside reset
`define SSPP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SSPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sspp_pkg.sv @@
// shared types and constants for the servo status packet parser
// no dependencies
package sspp_pkg;

    localparam int NUM_IDS_DEF = 16;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 16;
    localparam int IDX_W       = 3;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

    localparam logic CMD_RX   = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // position of a byte within the status frame
    localparam logic [IDX_W-1:0] IDX_SYNC1  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_SYNC2  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_ID     = 3'd2;
    localparam logic [IDX_W-1:0] IDX_LEN    = 3'd3;
    localparam logic [IDX_W-1:0] IDX_ERR    = 3'd4;
    localparam logic [IDX_W-1:0] IDX_POS_LO = 3'd5;
    localparam logic [IDX_W-1:0] IDX_POS_HI = 3'd6;
    localparam logic [IDX_W-1:0] IDX_CHECK  = 3'd7;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] query_id;
    } in_beat_t;

    typedef struct packed {
        logic              is_frame_report;
        logic [BYTE_W-1:0] frame_id;
        logic [POS_W-1:0]  frame_position;
        logic              checksum_ok;
        logic [POS_W-1:0]  read_position;
    } out_beat_t;

endpackage

@@ sv/sspp_ram.sv @@
// generic single write port, single read port ram with registered read
// depends on sspp_pkg for default sizes
module sspp_ram #(
    parameter int WIDTH = sspp_pkg::POS_W,
    parameter int DEPTH = sspp_pkg::NUM_IDS_DEF
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/servo_status_packet_parser.sv @@
// Servo status packet parser. One beat per cycle is accepted, sustained, on the input channel
// while the output is not stalled; a beat is either a received bus byte or a read of the
// position table. A beat enters an input register and is decoded in the next cycle. Its
// result, if it has one, is loaded into the output register when the input register advances.
// The registered read of the position table ram lines up with that output register.
// The parser hunts two 0xFF sync bytes, then collects id, length,
// error, position low, position high and checksum; the eighth byte yields a frame report, and
// a frame with a good checksum and an id below NUM_IDS updates the table. Every read yields one
// answer. Table entries never written since reset read as zero through per-entry valid bits,
// so no clearing pass is needed after reset. Output stalls back-pressure the input only when
// both stages are full.
// depends on sspp_pkg and sspp_ram
module servo_status_packet_parser #(
    parameter int NUM_IDS = sspp_pkg::NUM_IDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sspp_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sspp_pkg::out_beat_t out_data
);

    localparam int ID_W     = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int ID_CMP_W = sspp_pkg::BYTE_W + 1;

    logic                           s1_valid_reg;
    sspp_pkg::in_beat_t             s1_data_reg;
    logic [sspp_pkg::IDX_W-1:0]     byte_index_reg;
    logic [sspp_pkg::IDX_W-1:0]     byte_index_next;
    logic [sspp_pkg::BYTE_W-1:0]    frame_id_reg;
    logic [sspp_pkg::BYTE_W-1:0]    frame_id_next;
    logic [sspp_pkg::BYTE_W-1:0]    pos_lo_reg;
    logic [sspp_pkg::BYTE_W-1:0]    pos_lo_next;
    logic [sspp_pkg::BYTE_W-1:0]    pos_hi_reg;
    logic [sspp_pkg::BYTE_W-1:0]    pos_hi_next;
    logic [sspp_pkg::BYTE_W-1:0]    sum_reg;
    logic [sspp_pkg::BYTE_W-1:0]    sum_next;
    logic [NUM_IDS-1:0]             tbl_valid_reg;

    logic                           s2_valid_reg;
    logic                           s2_is_frame_reg;
    logic [sspp_pkg::BYTE_W-1:0]    s2_frame_id_reg;
    logic [sspp_pkg::POS_W-1:0]     s2_frame_pos_reg;
    logic                           s2_ok_reg;
    logic                           s2_hit_reg;

    logic                           adv;
    logic                           s1_take;
    logic                           is_rx;
    logic [sspp_pkg::BYTE_W-1:0]    rx;
    logic                           frame_done;
    logic                           frame_ok;
    logic                           id_in_range;
    logic                           qid_in_range;
    logic                           q_hit;
    logic                           result_valid;
    logic [sspp_pkg::POS_W-1:0]     frame_pos;
    logic                           ram_we;
    logic                           ram_re;
    logic [ID_W-1:0]                ram_waddr;
    logic [ID_W-1:0]                ram_raddr;
    logic [sspp_pkg::POS_W-1:0]     ram_rdata;

    assign adv      = !s2_valid_reg || out_ready;
    assign s1_take  = s1_valid_reg && adv;
    assign in_ready = !s1_valid_reg || adv;

    assign is_rx        = (s1_data_reg.cmd == sspp_pkg::CMD_RX);
    assign rx           = s1_data_reg.rx_byte;
    assign frame_done   = is_rx && (byte_index_reg == sspp_pkg::IDX_CHECK);
    assign id_in_range  = {1'b0, frame_id_reg} < ID_CMP_W'(NUM_IDS);
    assign frame_ok     = (rx == ~sum_reg) && id_in_range;
    assign frame_pos    = {pos_hi_reg, pos_lo_reg};
    assign qid_in_range = {1'b0, s1_data_reg.query_id} < ID_CMP_W'(NUM_IDS);
    assign ram_raddr    = s1_data_reg.query_id[ID_W-1:0];
    assign ram_waddr    = frame_id_reg[ID_W-1:0];
    assign q_hit        = qid_in_range && tbl_valid_reg[ram_raddr];
    assign result_valid = is_rx ? frame_done : 1'b1;
    assign ram_we       = s1_take && frame_done && frame_ok;
    assign ram_re       = s1_take && !is_rx;

    always_comb
    begin
        byte_index_next = byte_index_reg;
        frame_id_next   = frame_id_reg;
        pos_lo_next     = pos_lo_reg;
        pos_hi_next     = pos_hi_reg;
        sum_next        = sum_reg;
        unique case (byte_index_reg)
            sspp_pkg::IDX_SYNC1:
            begin
                byte_index_next = (rx == sspp_pkg::SYNC_BYTE) ? sspp_pkg::IDX_SYNC2
                                                              : sspp_pkg::IDX_SYNC1;
            end
            sspp_pkg::IDX_SYNC2:
            begin
                byte_index_next = (rx == sspp_pkg::SYNC_BYTE) ? sspp_pkg::IDX_ID
                                                              : sspp_pkg::IDX_SYNC1;
            end
            sspp_pkg::IDX_ID:
            begin
                byte_index_next = sspp_pkg::IDX_LEN;
                frame_id_next   = rx;
                sum_next        = rx;
            end
            sspp_pkg::IDX_LEN:
            begin
                byte_index_next = sspp_pkg::IDX_ERR;
                sum_next        = sum_reg + rx;
            end
            sspp_pkg::IDX_ERR:
            begin
                byte_index_next = sspp_pkg::IDX_POS_LO;
                sum_next        = sum_reg + rx;
            end
            sspp_pkg::IDX_POS_LO:
            begin
                byte_index_next = sspp_pkg::IDX_POS_HI;
                pos_lo_next     = rx;
                sum_next        = sum_reg + rx;
            end
            sspp_pkg::IDX_POS_HI:
            begin
                byte_index_next = sspp_pkg::IDX_CHECK;
                pos_hi_next     = rx;
                sum_next        = sum_reg + rx;
            end
            sspp_pkg::IDX_CHECK:
            begin
                byte_index_next = sspp_pkg::IDX_SYNC1;
            end
            default:
            begin
                byte_index_next = sspp_pkg::IDX_SYNC1;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            byte_index_reg <= sspp_pkg::IDX_SYNC1;
            tbl_valid_reg  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_take)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                s2_valid_reg <= s1_take && result_valid;
            end
            if (s1_take && is_rx)
            begin
                byte_index_reg <= byte_index_next;
            end
            if (ram_we)
            begin
                tbl_valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_take && is_rx)
        begin
            frame_id_reg <= frame_id_next;
            pos_lo_reg   <= pos_lo_next;
            pos_hi_reg   <= pos_hi_next;
            sum_reg      <= sum_next;
        end
        if (s1_take)
        begin
            s2_is_frame_reg  <= is_rx;
            s2_frame_id_reg  <= is_rx ? frame_id_reg : '0;
            s2_frame_pos_reg <= is_rx ? frame_pos : '0;
            s2_ok_reg        <= is_rx && frame_ok;
            s2_hit_reg       <= !is_rx && q_hit;
        end
    end

    sspp_ram #(
        .WIDTH (sspp_pkg::POS_W),
        .DEPTH (NUM_IDS)
    ) u_pos_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (frame_pos),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid = s2_valid_reg;

    always_comb
    begin
        out_data.is_frame_report = s2_is_frame_reg;
        out_data.frame_id        = s2_frame_id_reg;
        out_data.frame_position  = s2_frame_pos_reg;
        out_data.checksum_ok     = s2_ok_reg;
        out_data.read_position   = s2_hit_reg ? ram_rdata : '0;
    end

endmodule

@@ sv/sspp_checker.sv @@
// port-level checker for the servo status packet parser, bound to the top level
// depends on sspp_pkg and servo_status_packet_parser_assert.svh
`include "servo_status_packet_parser_assert.svh"

module sspp_checker #(
    parameter int NUM_IDS = sspp_pkg::NUM_IDS_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input sspp_pkg::out_beat_t out_data
);

    localparam int ID_CMP_W = sspp_pkg::BYTE_W + 1;

    `SSPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")
    `SSPP_ASSERT_ALWAYS(a_read_fields, !(out_valid && !out_data.is_frame_report) || (out_data.frame_id == '0 && out_data.frame_position == '0 && !out_data.checksum_ok), "read answer carries frame fields")
    `SSPP_ASSERT_ALWAYS(a_frame_fields, !(out_valid && out_data.is_frame_report) || (out_data.read_position == '0), "frame report carries a read position")
    `SSPP_ASSERT_ALWAYS(a_ok_id_range, !(out_valid && out_data.is_frame_report && out_data.checksum_ok) || ({1'b0, out_data.frame_id} < ID_CMP_W'(NUM_IDS)), "frame accepted with id past the table")

endmodule

bind servo_status_packet_parser sspp_checker #(
    .NUM_IDS (NUM_IDS)
) u_sspp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ verif/servo_status_packet_parser_checker.sv @@
`timescale 1ns / 1ps
// checker for the servo status packet parser: watches both channels, predicts
// frame reports and table reads, and compares every output beat in order
// depends on sspp_pkg
module servo_status_packet_parser_checker #(
    parameter int NUM_IDS = sspp_pkg::NUM_IDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  sspp_pkg::in_beat_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  sspp_pkg::out_beat_t out_data,
    output int                  fail_count,
    output int                  awaited
);

    localparam int FIELD_W = sspp_pkg::POS_W;

    logic [sspp_pkg::IDX_W-1:0]  frame_idx;
    logic [sspp_pkg::BYTE_W-1:0] frame_buf [8];
    logic [sspp_pkg::POS_W-1:0]  pos_table [NUM_IDS];
    sspp_pkg::out_beat_t         expected_reports [$];

    function automatic bit parse_beat(input sspp_pkg::in_beat_t b,
                                      output sspp_pkg::out_beat_t res);
        logic [sspp_pkg::BYTE_W-1:0] sum;
        logic [sspp_pkg::POS_W-1:0]  pos;
        res = '0;
        if (b.cmd == sspp_pkg::CMD_READ)
        begin
            if (b.query_id < NUM_IDS)
                res.read_position = pos_table[b.query_id];
            return 1'b1;
        end
        frame_buf[frame_idx] = b.rx_byte;
        case (frame_idx)
            sspp_pkg::IDX_SYNC1:
            begin
                if (b.rx_byte == sspp_pkg::SYNC_BYTE)
                    frame_idx = sspp_pkg::IDX_SYNC2;
                return 1'b0;
            end
            sspp_pkg::IDX_SYNC2:
            begin
                frame_idx = (b.rx_byte == sspp_pkg::SYNC_BYTE) ? sspp_pkg::IDX_ID
                                                               : sspp_pkg::IDX_SYNC1;
                return 1'b0;
            end
            sspp_pkg::IDX_CHECK: ;
            default:
            begin
                frame_idx = frame_idx + 1'b1;
                return 1'b0;
            end
        endcase
        frame_idx = sspp_pkg::IDX_SYNC1;
        sum = frame_buf[sspp_pkg::IDX_ID] + frame_buf[sspp_pkg::IDX_LEN]
            + frame_buf[sspp_pkg::IDX_ERR] + frame_buf[sspp_pkg::IDX_POS_LO]
            + frame_buf[sspp_pkg::IDX_POS_HI];
        pos = {frame_buf[sspp_pkg::IDX_POS_HI], frame_buf[sspp_pkg::IDX_POS_LO]};
        res.is_frame_report = 1'b1;
        res.frame_id        = frame_buf[sspp_pkg::IDX_ID];
        res.frame_position  = pos;
        if ((sspp_pkg::SYNC_BYTE - sum) == frame_buf[sspp_pkg::IDX_CHECK]
            && frame_buf[sspp_pkg::IDX_ID] < NUM_IDS)
        begin
            pos_table[frame_buf[sspp_pkg::IDX_ID]] = pos;
            res.checksum_ok = 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic compare_field(input string fname, input logic [FIELD_W-1:0] want_v,
                                 input logic [FIELD_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        sspp_pkg::out_beat_t predicted;
        sspp_pkg::out_beat_t want;
        if (!rst_n)
        begin
            frame_idx = sspp_pkg::IDX_SYNC1;
            for (int i = 0; i < NUM_IDS; i++)
                pos_table[i] = '0;
            expected_reports.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (parse_beat(in_data, predicted))
                    expected_reports.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected output beat, expected none, actual %h",
                             $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("is_frame_report", FIELD_W'(want.is_frame_report),
                                  FIELD_W'(out_data.is_frame_report));
                    compare_field("frame_id", FIELD_W'(want.frame_id),
                                  FIELD_W'(out_data.frame_id));
                    compare_field("frame_position", want.frame_position,
                                  out_data.frame_position);
                    compare_field("checksum_ok", FIELD_W'(want.checksum_ok),
                                  FIELD_W'(out_data.checksum_ok));
                    compare_field("read_position", want.read_position,
                                  out_data.read_position);
                end
            end
        end
        awaited = expected_reports.size();
    end

endmodule

@@ verif/servo_status_packet_parser_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the servo status packet parser: drives bus bytes and table
// reads with random gaps and back-pressure, and gives the verdict
// depends on sspp_pkg, servo_status_packet_parser and its checker
module servo_status_packet_parser_tb;

    localparam int NUM_IDS    = sspp_pkg::NUM_IDS_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int ITEM_GOAL  = 600;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    sspp_pkg::in_beat_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    sspp_pkg::out_beat_t out_data;
    int                  fail_count;
    int                  awaited;
    int                  items_sent = 0;
    int                  idle_cycles = 0;

    servo_status_packet_parser #(.NUM_IDS(NUM_IDS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    servo_status_packet_parser_checker #(.NUM_IDS(NUM_IDS)) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [sspp_pkg::BYTE_W-1:0] pick_id();
        if ($urandom_range(0, 4) != 0)
            return 8'($urandom_range(0, NUM_IDS - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [sspp_pkg::BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [sspp_pkg::BYTE_W-1:0] frame_checksum(
        input logic [sspp_pkg::BYTE_W-1:0] id, len, err, lo, hi);
        logic [sspp_pkg::BYTE_W-1:0] sum;
        sum = id + len + err + lo + hi;
        return sspp_pkg::SYNC_BYTE - sum;
    endfunction

    task automatic send_beat(input sspp_pkg::in_beat_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_rx(input logic [sspp_pkg::BYTE_W-1:0] x);
        sspp_pkg::in_beat_t b;
        b.cmd      = sspp_pkg::CMD_RX;
        b.rx_byte  = x;
        b.query_id = 8'($urandom_range(0, 255));
        send_beat(b);
    endtask

    task automatic send_read(input logic [sspp_pkg::BYTE_W-1:0] id);
        sspp_pkg::in_beat_t b;
        b.cmd      = sspp_pkg::CMD_READ;
        b.rx_byte  = 8'($urandom_range(0, 255));
        b.query_id = id;
        send_beat(b);
    endtask

    task automatic send_frame(input logic [sspp_pkg::BYTE_W-1:0] id, len, err, lo, hi,
                              input bit good, input bit mixed);
        logic [sspp_pkg::BYTE_W-1:0] chk_byte;
        logic [63:0]                 bytes;
        chk_byte = frame_checksum(id, len, err, lo, hi);
        if (!good)
            chk_byte ^= 8'($urandom_range(1, 255));
        bytes = {sspp_pkg::SYNC_BYTE, sspp_pkg::SYNC_BYTE, id, len, err, lo, hi, chk_byte};
        for (int k = 0; k < 8; k++)
        begin
            if (mixed && k > 0 && $urandom_range(0, 9) == 0)
                send_read(pick_id());
            send_rx(bytes[63 - 8*k -: 8]);
        end
    endtask

    // zero bytes walk any partial frame to its end and leave the parser hunting
    task automatic resync();
        repeat (8) send_rx(8'h00);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (awaited != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int  r;
        bit  paused;
        paused = 1'b0;
        @(posedge rst_n);
        @(negedge clk);

        send_read(8'h00);
        send_frame(8'h0F, 8'h04, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
        send_read(8'h0F);
        send_read(8'hFF);
        send_rx(sspp_pkg::SYNC_BYTE);
        send_rx(8'h00);
        send_frame(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        // id past the table, with a read in the middle of the frame
        send_rx(sspp_pkg::SYNC_BYTE);
        send_rx(sspp_pkg::SYNC_BYTE);
        send_rx(8'hFF);
        send_rx(8'h00);
        send_read(8'h00);
        send_rx(8'h00);
        send_rx(8'h34);
        send_rx(8'h12);
        send_rx(frame_checksum(8'hFF, 8'h00, 8'h00, 8'h34, 8'h12));
        drain_results();

        while (items_sent < ITEM_GOAL)
        begin
            if (!paused && items_sent >= 400)
            begin
                paused = 1'b1;
                drain_results();
            end
            r = $urandom_range(0, 99);
            if (r < 60)
                send_frame(pick_id(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                           $urandom_range(0, 99) < 85, 1'b1);
            else if (r < 75)
                send_read(pick_id());
            else if (r < 85)
            begin
                repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(0, 255)));
                resync();
            end
            else if (r < 95)
            begin
                send_rx(sspp_pkg::SYNC_BYTE);
                repeat ($urandom_range(0, 6)) send_rx(pick_byte());
                resync();
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_rx(sspp_pkg::SYNC_BYTE);
                resync();
            end
        end

        in_valid <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : sink
        int  gap;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clk);
            gap = pick_gap();
            if (!held && items_sent >= 250)
            begin
                held = 1'b1;
                gap  = 120;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

@@ files.f @@
+incdir+sv
sv/sspp_pkg.sv
sv/sspp_ram.sv
sv/servo_status_packet_parser.sv
sv/sspp_checker.sv
verif/servo_status_packet_parser_checker.sv
verif/servo_status_packet_parser_tb.sv
